// File: rtl/tbsp_pkg.sv
// Shared codes, constants and types of the telemetry batch stream parser.
package tbsp_pkg;

  // parser phases, also used as byte roles
  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_SCHEMA  = 4'd1;
  localparam logic [3:0] PH_COUNT   = 4'd2;
  localparam logic [3:0] PH_TYPE    = 4'd3;
  localparam logic [3:0] PH_NAMELEN = 4'd4;
  localparam logic [3:0] PH_NAME    = 4'd5;
  localparam logic [3:0] PH_VALLEN  = 4'd6;
  localparam logic [3:0] PH_VALUE   = 4'd7;
  localparam logic [3:0] PH_IGNORE  = 4'd8;

  // status codes
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_OK    = 3'd1;
  localparam logic [2:0] ST_MAGIC = 3'd2;
  localparam logic [2:0] ST_SHORT = 3'd3;
  localparam logic [2:0] ST_LIMIT = 3'd4;

  localparam logic [31:0] MAGIC_WORD       = 32'h4D4C_5449;  // "ITLM", little endian
  localparam logic [15:0] MAX_POINTS_RESET = 16'd2048;
  localparam logic [3:0]  HEADER_BYTES     = 4'd8;

  // register indexes on the configuration port
  localparam logic REG_MAX_POINTS = 1'b0;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  byte_out;
    logic [15:0] point_index;
    logic [31:0] field_value;
    logic        field_done;
    logic [2:0]  status;
  } res_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = MAGIC_WORD[7:0];
      2'd1:    b = MAGIC_WORD[15:8];
      2'd2:    b = MAGIC_WORD[23:16];
      default: b = MAGIC_WORD[31:24];
    endcase
    return b;
  endfunction

endpackage

// File: rtl/tbsp_cfg.sv
// APB-style register file holding the point count limit.
module tbsp_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_points_o
);
  import tbsp_pkg::*;

  logic [15:0] max_points_q;
  logic        reg_hit;
  logic        wr_en;

  assign reg_hit = (paddr[2] == REG_MAX_POINTS);
  assign wr_en   = psel & penable & pwrite & pready & reg_hit;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_points_q <= MAX_POINTS_RESET;
    end else if (wr_en) begin
      max_points_q <= pwdata[15:0];
    end
  end

  // low two address bits select bytes within the word and are not decoded
  assign prdata       = reg_hit ? {16'd0, max_points_q} : 32'd0;
  assign max_points_o = max_points_q;

endmodule

// File: rtl/tbsp_core.sv
// Input register and one-step message parser state machine.
module tbsp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  input  logic               end_of_message_i,
  input  logic [15:0]        max_points_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output tbsp_pkg::res_t     res_o
);
  import tbsp_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eom_q;
  logic       adv;
  logic       in_load;

  // message state
  logic [3:0]  phase_q,   phase_d;
  logic [1:0]  pos_q,     pos_d;
  logic [31:0] acc_q,     acc_d;
  logic [31:0] rem_q,     rem_d;
  logic [15:0] total_q,   total_d;
  logic [15:0] cur_q,     cur_d;
  logic [2:0]  err_q,     err_d;
  logic [3:0]  len_q,     len_d;

  logic [31:0] acc_cur;
  logic [31:0] rem_dec;
  logic [15:0] cur_inc;
  logic [3:0]  len_inc;
  logic        last2;
  logic        last4;
  res_t        res;

  assign adv        = in_valid_q & res_take_i;
  assign in_load    = ~in_valid_q | adv;
  assign in_stall_o = ~in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      byte_q <= byte_in_i;
      eom_q  <= end_of_message_i;
    end
  end

  assign acc_cur = acc_q | ({24'd0, byte_q} << {pos_q, 3'b000});
  assign rem_dec = rem_q - 32'd1;
  assign cur_inc = cur_q + 16'd1;
  assign len_inc = (len_q < HEADER_BYTES) ? len_q + 4'd1 : len_q;
  assign last2   = (pos_q != 2'd0);
  assign last4   = (pos_q == 2'd3);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    total_d = total_q;
    cur_d   = cur_q;
    err_d   = err_q;
    len_d   = len_inc;

    res.byte_role   = PH_IGNORE;
    res.byte_out    = byte_q;
    res.point_index = 16'd0;
    res.field_value = 32'd0;
    res.field_done  = 1'b0;
    res.status      = ST_RUN;

    case (phase_q)
      PH_MAGIC: begin
        res.byte_role = PH_MAGIC;
        if (byte_q != magic_byte(pos_q)) begin
          err_d   = ST_MAGIC;
          phase_d = PH_IGNORE;
        end else if (last4) begin
          res.field_done  = 1'b1;
          res.field_value = acc_cur;
          acc_d   = 32'd0;
          pos_d   = 2'd0;
          phase_d = PH_SCHEMA;
        end else begin
          acc_d = acc_cur;
          pos_d = pos_q + 2'd1;
        end
      end
      PH_SCHEMA: begin
        res.byte_role = PH_SCHEMA;
        if (last2) begin
          res.field_done  = 1'b1;
          res.field_value = acc_cur;
          acc_d   = 32'd0;
          pos_d   = 2'd0;
          phase_d = PH_COUNT;
        end else begin
          acc_d = acc_cur;
          pos_d = pos_q + 2'd1;
        end
      end
      PH_COUNT: begin
        res.byte_role = PH_COUNT;
        if (last2) begin
          res.field_done  = 1'b1;
          res.field_value = acc_cur;
          acc_d   = 32'd0;
          pos_d   = 2'd0;
          total_d = acc_cur[15:0];
          cur_d   = 16'd0;
          if (acc_cur[15:0] > max_points_i) begin
            err_d   = ST_LIMIT;
            phase_d = PH_IGNORE;
          end else begin
            phase_d = (acc_cur[15:0] == 16'd0) ? PH_IGNORE : PH_TYPE;
          end
        end else begin
          acc_d = acc_cur;
          pos_d = pos_q + 2'd1;
        end
      end
      PH_TYPE: begin
        res.byte_role   = PH_TYPE;
        res.point_index = cur_q;
        res.field_done  = 1'b1;
        res.field_value = {24'd0, byte_q};
        phase_d = PH_NAMELEN;
      end
      PH_NAMELEN: begin
        res.byte_role   = PH_NAMELEN;
        res.point_index = cur_q;
        if (last2) begin
          res.field_done  = 1'b1;
          res.field_value = acc_cur;
          acc_d   = 32'd0;
          pos_d   = 2'd0;
          rem_d   = acc_cur;
          phase_d = (acc_cur == 32'd0) ? PH_VALLEN : PH_NAME;
        end else begin
          acc_d = acc_cur;
          pos_d = pos_q + 2'd1;
        end
      end
      PH_NAME: begin
        res.byte_role   = PH_NAME;
        res.point_index = cur_q;
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_d = PH_VALLEN;
        end
      end
      PH_VALLEN: begin
        res.byte_role   = PH_VALLEN;
        res.point_index = cur_q;
        if (last4) begin
          res.field_done  = 1'b1;
          res.field_value = acc_cur;
          acc_d = 32'd0;
          pos_d = 2'd0;
          rem_d = acc_cur;
          if (acc_cur == 32'd0) begin
            cur_d   = cur_inc;
            phase_d = (cur_inc >= total_q) ? PH_IGNORE : PH_TYPE;
          end else begin
            phase_d = PH_VALUE;
          end
        end else begin
          acc_d = acc_cur;
          pos_d = pos_q + 2'd1;
        end
      end
      PH_VALUE: begin
        res.byte_role   = PH_VALUE;
        res.point_index = cur_q;
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          cur_d   = cur_inc;
          phase_d = (cur_inc >= total_q) ? PH_IGNORE : PH_TYPE;
        end
      end
      default: begin
        res.byte_role = PH_IGNORE;
        phase_d       = PH_IGNORE;
      end
    endcase

    if (err_d != ST_RUN) begin
      res.status = err_d;
    end else if (!eom_q) begin
      res.status = ST_RUN;
    end else if (phase_d == PH_IGNORE) begin
      res.status = ST_OK;
    end else if (len_inc < HEADER_BYTES) begin
      res.status = ST_MAGIC;
    end else begin
      res.status = ST_SHORT;
    end

    // final byte returns the message state to its idle values
    if (eom_q) begin
      phase_d = PH_MAGIC;
      pos_d   = 2'd0;
      acc_d   = 32'd0;
      rem_d   = 32'd0;
      total_d = 16'd0;
      cur_d   = 16'd0;
      err_d   = ST_RUN;
      len_d   = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      pos_q   <= 2'd0;
      acc_q   <= 32'd0;
      rem_q   <= 32'd0;
      total_q <= 16'd0;
      cur_q   <= 16'd0;
      err_q   <= ST_RUN;
      len_q   <= 4'd0;
    end else if (adv) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      total_q <= total_d;
      cur_q   <= cur_d;
      err_q   <= err_d;
      len_q   <= len_d;
    end
  end

  assign res_valid_o = in_valid_q;
  assign res_o       = res;

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= HEADER_BYTES)
    else $error("byte count above header size");

  a_eom_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && eom_q |=> phase_q == PH_MAGIC && len_q == 4'd0 && err_q == ST_RUN)
    else $error("message state not cleared after final byte");

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_NAME || phase_q == PH_VALUE) |-> rem_q != 32'd0)
    else $error("payload phase with nothing left to read");

  a_point_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TYPE || phase_q == PH_NAMELEN || phase_q == PH_NAME ||
     phase_q == PH_VALLEN || phase_q == PH_VALUE) |-> cur_q < total_q)
    else $error("point index beyond point count");

endmodule

// File: rtl/tbsp_out.sv
// Output register stage for parsed byte results.
module tbsp_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_valid_i,
  output logic            res_take_o,
  input  tbsp_pkg::res_t  res_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tbsp_pkg::res_t  out_o
);
  import tbsp_pkg::*;

  logic out_valid_q;
  res_t out_q;
  logic load;

  assign load       = ~out_valid_q | ~out_stall_i;
  assign res_take_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && res_valid_i) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/telemetry_batch_stream_parser_unit.sv
// Top level of the telemetry batch stream parser.
// Parses one message byte per clock cycle while out_stall_i does not hold the
// output: the byte is registered, the parser state machine takes one step on it
// and the tagged result is registered at the output. Each byte comes out with
// its role, point index, any completed little-endian field and the message
// status; end_of_message_i on the final byte returns the parser to its idle
// state for the next message. The point count limit (max_points, reset 2048)
// sits at address 0 of the APB-style port and should be written only while no
// message bytes are in flight.
module telemetry_batch_stream_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  byte_role_o,
  output logic [7:0]  byte_out_o,
  output logic [15:0] point_index_o,
  output logic [31:0] field_value_o,
  output logic        field_done_o,
  output logic [2:0]  status_o
);
  import tbsp_pkg::*;

  logic [15:0] max_points;
  logic        res_valid;
  logic        res_take;
  res_t        res;
  res_t        out_res;

  tbsp_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_points_o (max_points)
  );

  tbsp_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .byte_in_i        (byte_in_i),
    .end_of_message_i (end_of_message_i),
    .max_points_i     (max_points),
    .res_valid_o      (res_valid),
    .res_take_i       (res_take),
    .res_o            (res)
  );

  tbsp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_take_o  (res_take),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign byte_role_o   = out_res.byte_role;
  assign byte_out_o    = out_res.byte_out;
  assign point_index_o = out_res.point_index;
  assign field_value_o = out_res.field_value;
  assign field_done_o  = out_res.field_done;
  assign status_o      = out_res.status;

endmodule
